[hdl/text_cursor_placement_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the text cursor placement core
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CURSOR_PLACEMENT_CORE_ASSERT_SVH
`define TEXT_CURSOR_PLACEMENT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define TCP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcp check failed: lbl");

// Next-cycle implication
`define TCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcp check failed: lbl");

`else

`define TCP_ASSERT_SAME(lbl, ante, cons)
`define TCP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/tcp_pkg.sv]
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants of the text cursor placement core.
// ----------------------------------------------------------------------------
package tcp_pkg;

	// Control characters
	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_CR  = 8'd13;

	// Tab stop spacing is 1 << TAB_SHIFT columns
	localparam int TAB_SHIFT = 3;

	localparam logic signed [7:0] CURSOR_MAX = 8'sd127;

	// Request command
	typedef enum logic {
		CMD_PUT  = 1'b0,
		CMD_GOTO = 1'b1
	} tcp_cmd_e;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_WINDOW_COLS = 3'd0,
		REG_WINDOW_ROWS = 3'd1,
		REG_X_ORIGIN    = 3'd2,
		REG_Y_ORIGIN    = 3'd3,
		REG_WRAP_ENABLE = 3'd4,
		REG_TEXT_COLOR  = 3'd5,
		REG_BACK_COLOR  = 3'd6,
		REG_SWAP_COLORS = 3'd7
	} tcp_reg_e;

	typedef struct packed {
		logic [6:0]  window_cols;
		logic [6:0]  window_rows;
		logic [9:0]  window_x_origin;
		logic [9:0]  window_y_origin;
		logic        wrap_enable;
		logic [15:0] text_color;
		logic [15:0] back_color;
		logic        swap_colors;
	} tcp_cfg_t;

	typedef struct packed {
		logic               draw_glyph;
		logic [11:0]        pixel_x;
		logic [11:0]        pixel_y;
		logic [7:0]         glyph_code;
		logic [15:0]        glyph_fore;
		logic [15:0]        glyph_back;
		logic signed [7:0]  cursor_row;
	} tcp_res_t;

	typedef struct packed {
		logic signed [7:0] col;
		logic signed [7:0] line;
	} tcp_cursor_t;

endpackage

[hdl/text_cursor_placement_core.sv]
// ----------------------------------------------------------------------------
// text_cursor_placement_core
// Character-window cursor with wrap, tab and newline; emits glyph draws.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a character to
//   put, or a move of the cursor to a signed column and row. Every request
//   gives exactly one result on the output channel (out_valid / out_stall):
//   a glyph draw with pixel position, code and colours, or an empty result
//   with draw_glyph low, always with the cursor row after the request.
//   With no stall, an accepted request is registered in the output register.
//   Throughput is one request per cycle while in_stall is low; the cursor
//   update is a few compares and adds on the two cursor registers, done in
//   the accepting cycle, so back-to-back requests see each other's result.
//   When the receiver stalls, the output register holds its result and a
//   one-entry skid register takes one more request; in_stall rises only once
//   that skid entry is full, and falls the cycle after the output drains.
//   Configuration is written through cfg_we / cfg_index / cfg_data, one
//   register per cycle, and should only change while no request is pending.
//   Reset clears the cursor to column 0, row 0, empties both output stages
//   and loads the default window of 40 by 15 with wrap on, white on black.
// ----------------------------------------------------------------------------
module text_cursor_placement_core #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [7:0]         char_code,
	input  logic signed [7:0]  goto_col,
	input  logic signed [7:0]  goto_row,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               draw_glyph,
	output logic [11:0]        pixel_x,
	output logic [11:0]        pixel_y,
	output logic [7:0]         glyph_code,
	output logic [15:0]        glyph_fore,
	output logic [15:0]        glyph_back,
	output logic signed [7:0]  cursor_row
);
	import tcp_pkg::*;

	`include "text_cursor_placement_core_assert.svh"

	tcp_cfg_t    cfg_q;
	tcp_cursor_t cursor_q;
	tcp_cursor_t cursor_nxt;
	tcp_res_t    step_res;
	tcp_res_t    out_q;
	tcp_res_t    skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;
	logic        in_acc;
	logic        out_take;

	assign in_acc   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = skid_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_cols     <= 7'd40;
			cfg_q.window_rows     <= 7'd15;
			cfg_q.window_x_origin <= '0;
			cfg_q.window_y_origin <= '0;
			cfg_q.wrap_enable     <= 1'b1;
			cfg_q.text_color      <= 16'hFFFF;
			cfg_q.back_color      <= '0;
			cfg_q.swap_colors     <= 1'b0;
		end else if (cfg_we) begin
			case (tcp_reg_e'(cfg_index))
				REG_WINDOW_COLS: cfg_q.window_cols     <= cfg_data[6:0];
				REG_WINDOW_ROWS: cfg_q.window_rows     <= cfg_data[6:0];
				REG_X_ORIGIN:    cfg_q.window_x_origin <= cfg_data[9:0];
				REG_Y_ORIGIN:    cfg_q.window_y_origin <= cfg_data[9:0];
				REG_WRAP_ENABLE: cfg_q.wrap_enable     <= cfg_data[0];
				REG_TEXT_COLOR:  cfg_q.text_color      <= cfg_data;
				REG_BACK_COLOR:  cfg_q.back_color      <= cfg_data;
				REG_SWAP_COLORS: cfg_q.swap_colors     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// cursor update and result for the incoming request
	tcp_step #(
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.GLYPH_HEIGHT (GLYPH_HEIGHT)
	) u_step (
		.cfg       (cfg_q),
		.command   (command),
		.char_code (char_code),
		.goto_col  (goto_col),
		.goto_row  (goto_row),
		.cur       (cursor_q),
		.nxt       (cursor_nxt),
		.res       (step_res)
	);

	// cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (in_acc) begin
			cursor_q <= cursor_nxt;
		end
	end

	// output and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_acc)
				out_q <= step_res;
		end else if (in_acc) begin
			skid_q <= step_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign draw_glyph = out_q.draw_glyph;
	assign pixel_x    = out_q.pixel_x;
	assign pixel_y    = out_q.pixel_y;
	assign glyph_code = out_q.glyph_code;
	assign glyph_fore = out_q.glyph_fore;
	assign glyph_back = out_q.glyph_back;
	assign cursor_row = out_q.cursor_row;

	// checks
	`TCP_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q)
	`TCP_ASSERT_SAME(a_skid_fill_on_stall, $rose(skid_valid_q), $past(out_valid_q && out_stall))
	`TCP_ASSERT_NEXT(a_cursor_hold_idle, !in_acc, $stable(cursor_q))
	`TCP_ASSERT_SAME(a_empty_result_clear, out_valid_q && !out_q.draw_glyph, (out_q.pixel_x == '0) && (out_q.glyph_code == '0) && (out_q.glyph_fore == '0))

endmodule

[hdl/tcp_step.sv]
// ----------------------------------------------------------------------------
// tcp_step
// Combinational cursor update and glyph result for one request.
// ----------------------------------------------------------------------------
module tcp_step #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 16
) (
	input  tcp_pkg::tcp_cfg_t    cfg,
	input  logic                 command,
	input  logic [7:0]           char_code,
	input  logic signed [7:0]    goto_col,
	input  logic signed [7:0]    goto_row,
	input  tcp_pkg::tcp_cursor_t cur,
	output tcp_pkg::tcp_cursor_t nxt,
	output tcp_pkg::tcp_res_t    res
);
	import tcp_pkg::*;

	localparam logic [11:0] GW = 12'(GLYPH_WIDTH);
	localparam logic [11:0] GH = 12'(GLYPH_HEIGHT);

	logic signed [7:0] col_w, line_w;
	logic signed [8:0] tab_sum;
	logic signed [8:0] tab_stop;
	logic              in_window;

	always_comb begin
		nxt = cur;
		res = '0;
		col_w = cur.col;
		line_w = cur.line;
		tab_sum = 9'(cur.col) + 9'sd8;
		tab_stop = '0;
		in_window = 1'b0;

		if (tcp_cmd_e'(command) == CMD_GOTO) begin
			nxt.col = goto_col;
			nxt.line = goto_row;
		end else begin
			// wrap past the last column, then past the last row
			if (cfg.wrap_enable && !cur.col[7] && (cur.col[6:0] >= cfg.window_cols)) begin
				col_w = '0;
				line_w = (cur.line == CURSOR_MAX) ? CURSOR_MAX : cur.line + 8'sd1;
			end
			if (cfg.wrap_enable && !line_w[7] && (line_w[6:0] >= cfg.window_rows))
				line_w = '0;

			tab_sum = 9'(col_w) + 9'sd8;
			tab_stop = {tab_sum[8:TAB_SHIFT], {TAB_SHIFT{1'b0}}};
			in_window = !col_w[7] && (col_w[6:0] < cfg.window_cols) &&
				!line_w[7] && (line_w[6:0] < cfg.window_rows);

			nxt.col = col_w;
			nxt.line = line_w;

			if (char_code == CHAR_TAB) begin
				// floor to the tab stop, saturate at the top column
				if (!tab_stop[8] && tab_stop[7])
					nxt.col = CURSOR_MAX;
				else
					nxt.col = tab_stop[7:0];
			end else if (char_code == CHAR_LF) begin
				nxt.col = '0;
				nxt.line = (line_w == CURSOR_MAX) ? CURSOR_MAX : line_w + 8'sd1;
			end else if (char_code != CHAR_CR) begin
				if (in_window) begin
					res.draw_glyph = 1'b1;
					res.pixel_x = 12'(col_w[6:0]) * GW + 12'(cfg.window_x_origin);
					res.pixel_y = 12'(line_w[6:0]) * GH + 12'(cfg.window_y_origin);
					res.glyph_code = char_code;
					res.glyph_fore = cfg.swap_colors ? cfg.back_color : cfg.text_color;
					res.glyph_back = cfg.swap_colors ? cfg.text_color : cfg.back_color;
				end
				nxt.col = (col_w == CURSOR_MAX) ? CURSOR_MAX : col_w + 8'sd1;
			end
		end
		res.cursor_row = nxt.line;
	end

endmodule
